// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed in the following cycle");

`endif

// ----- hw/rtl/fcw_pkg.sv -----
// ----------------------------------------------------------------------------
// FAT12 chain walker package
// Commands, table constants and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package fcw_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_NEXT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [11:0] END_MARK   = 12'hFF0;
  localparam logic [11:0] ENTRY_MASK = 12'hFFF;
  localparam logic [12:0] COUNT_MAX  = 13'd4096;
  localparam logic [14:0] BASE_RESET = 15'd33;
  // Adding this constant modulo 2^16 subtracts two.
  localparam logic [15:0] MINUS_TWO  = 16'hFFFE;

  localparam logic STATUS_SECTOR = 1'b0;
  localparam logic STATUS_IDLE   = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_BASE = 8'b0000_0010,
    S_LBA  = 8'b0000_0100,
    S_OFF  = 8'b0000_1000,
    S_RD0  = 8'b0001_0000,
    S_RD1  = 8'b0010_0000,
    S_CAP  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

endpackage

// ----- hw/rtl/fcw_if.sv -----
// ----------------------------------------------------------------------------
// FAT12 chain walker channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface fcw_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [12:0] byte_addr;
  logic [7:0]  byte_value;
  logic [11:0] start_cluster;

  modport source (output valid, cmd, byte_addr, byte_value, start_cluster, input ready);
  modport sink (input valid, cmd, byte_addr, byte_value, start_cluster, output ready);
endinterface

interface fcw_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] sector_lba;
  logic        last;
  logic [12:0] sector_count;
  logic        status;

  modport source (output valid, sector_lba, last, sector_count, status, input ready);
  modport sink (input valid, sector_lba, last, sector_count, status, output ready);
endinterface

// ----- hw/rtl/fcw_table.sv -----
// ----------------------------------------------------------------------------
// FAT12 chain walker table memory
// Byte-wide allocation table with one write port and a registered read port.
// ----------------------------------------------------------------------------
module fcw_table #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fat12_cluster_chain_walker_top.sv -----
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker
// Loads an allocation table and walks a file's cluster chain sector by sector.
// ----------------------------------------------------------------------------
// A load beat (cmd 0) writes one table byte; it produces no result. A start
// beat (cmd 1) opens a chain at start_cluster, and a next beat (cmd 2)
// advances it; each returns one result beat with the sector address of the
// current cluster, the running sector count and a last flag that is set when
// the cluster's table entry marks the end of the chain. A next beat with no
// open chain returns a result with status 1 and zero fields. A start or next
// beat on an open chain runs through S_BASE to S_EMIT to the result: one
// 16-bit adder is shared by the sequencer for the base offset, the sector
// address, the table offset, the second byte address and the count, and the
// two table bytes come one after the other from the single read port of the
// table memory. The block holds ready low during that walk and while a
// finished result still waits. The user must write data_area_base through
// cfg_we/cfg_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_top
  import fcw_pkg::*;
#(
  parameter int FAT_BYTES = 8192
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [14:0]   cfg_data,
  fcw_cmd_if.sink       req,
  fcw_res_if.source     rsp
);

  localparam int AW = $clog2(FAT_BYTES);

  state_t      state;
  state_t      state_next;

  logic [14:0] data_area_base;
  logic [11:0] cluster;
  logic [12:0] count;
  logic        active;

  // Shared adder.
  logic [15:0] add_a;
  logic [15:0] add_b;
  logic [15:0] add_sum;

  logic [15:0] lba;
  logic [12:0] ptr;
  logic        ptr_ok;
  logic        rd_ok;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic        idle_rsp;

  logic        req_fire;
  logic        slot_free;
  logic        emit;
  logic [15:0] word;
  logic [11:0] entry;
  logic        is_end;

  logic [AW+12:0] waddr_wide;
  logic [AW+12:0] raddr_wide;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic           load_ok;
  logic           tbl_we;
  logic [7:0]     rdata;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign slot_free = !rsp.valid || rsp.ready;
  assign emit      = (state == S_EMIT) && slot_free;

  // Table addressing; bytes at or beyond the table size are dropped on
  // load and read back as zero.
  assign waddr_wide = {{AW{1'b0}}, req.byte_addr};
  assign raddr_wide = {{AW{1'b0}}, ptr};
  assign waddr      = waddr_wide[AW-1:0];
  assign raddr      = raddr_wide[AW-1:0];
  assign load_ok    = {19'd0, req.byte_addr} < 32'(FAT_BYTES);
  assign ptr_ok     = {19'd0, ptr} < 32'(FAT_BYTES);
  assign tbl_we     = req_fire && (req.cmd == CMD_LOAD) && load_ok;

  fcw_table #(
    .DEPTH (FAT_BYTES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (req.byte_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Operand selection for the shared adder.
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state)
      S_BASE: begin
        add_a = {1'b0, data_area_base};
        add_b = MINUS_TWO;
      end
      S_LBA: begin
        add_a = lba;
        add_b = {4'd0, cluster};
      end
      S_OFF: begin
        add_a = {4'd0, cluster};
        add_b = {5'd0, cluster[11:1]};
      end
      S_RD0: begin
        add_a = {3'd0, ptr};
        add_b = 16'd1;
      end
      S_CAP: begin
        add_a = {3'd0, count};
        add_b = 16'd1;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // Odd clusters take the upper twelve bits of the little-endian word.
  assign word   = {hi_byte, lo_byte};
  assign entry  = cluster[0] ? word[15:4] : (word[11:0] & ENTRY_MASK);
  assign is_end = entry >= END_MARK;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.cmd == CMD_START) begin
            state_next = S_BASE;
          end else if (req.cmd == CMD_NEXT) begin
            state_next = active ? S_BASE : S_EMIT;
          end
        end
      end
      S_BASE:  state_next = S_LBA;
      S_LBA:   state_next = S_OFF;
      S_OFF:   state_next = S_RD0;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_CAP;
      S_CAP:   state_next = S_EMIT;
      S_EMIT:  state_next = slot_free ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      data_area_base <= BASE_RESET;
      cluster        <= '0;
      count          <= '0;
      active         <= 1'b0;
      idle_rsp       <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        data_area_base <= cfg_data;
      end
      if (req_fire) begin
        idle_rsp <= (req.cmd == CMD_NEXT) && !active;
        if (req.cmd == CMD_START) begin
          cluster <= req.start_cluster;
          count   <= '0;
          active  <= 1'b1;
        end
      end
      if (state == S_CAP && count < COUNT_MAX) begin
        count <= add_sum[12:0];
      end
      if (emit && !idle_rsp) begin
        if (is_end) begin
          active <= 1'b0;
        end else begin
          cluster <= entry;
        end
      end
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_BASE: lba <= add_sum;
      S_LBA:  lba <= add_sum;
      S_OFF:  ptr <= add_sum[12:0];
      S_RD0: begin
        ptr   <= add_sum[12:0];
        rd_ok <= ptr_ok;
      end
      S_RD1: begin
        lo_byte <= rd_ok ? rdata : 8'd0;
        rd_ok   <= ptr_ok;
      end
      S_CAP:  hi_byte <= rd_ok ? rdata : 8'd0;
      default: begin
      end
    endcase
    if (emit) begin
      if (idle_rsp) begin
        rsp.sector_lba   <= '0;
        rsp.last         <= 1'b0;
        rsp.sector_count <= '0;
        rsp.status       <= STATUS_IDLE;
      end else begin
        rsp.sector_lba   <= lba;
        rsp.last         <= is_end;
        rsp.sector_count <= count;
        rsp.status       <= STATUS_SECTOR;
      end
    end
  end

endmodule

// ----- hw/rtl/fcw_checker.sv -----
// ----------------------------------------------------------------------------
// FAT12 chain walker checker
// Port-level assertions on the walker, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcw_checker
  import fcw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_cmd,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_sector_lba,
  input logic        rsp_last,
  input logic [12:0] rsp_sector_count,
  input logic        rsp_status
);

  // A stalled result beat keeps its payload.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sector_lba) && $stable(rsp_last) && $stable(rsp_sector_count) && $stable(rsp_status))

  // An idle status carries zero fields.
  `ASSERT_SAME(a_idle_zero, clk, rst, rsp_valid && rsp_status == STATUS_IDLE, rsp_sector_lba == 16'd0 && !rsp_last && rsp_sector_count == 13'd0)

  // A sector beat counts itself, and the count saturates.
  `ASSERT_SAME(a_count_range, clk, rst, rsp_valid && rsp_status == STATUS_SECTOR, rsp_sector_count != 13'd0 && rsp_sector_count <= COUNT_MAX)

  // A start beat occupies the walker in the following cycle.
  `ASSERT_NEXT(a_start_busy, clk, rst, req_valid && req_ready && req_cmd == CMD_START, !req_ready)

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_cmd          (req.cmd),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_sector_lba   (rsp.sector_lba),
  .rsp_last         (rsp.last),
  .rsp_sector_count (rsp.sector_count),
  .rsp_status       (rsp.status)
);
